/* design/dns_name_label_encoder_top_assert.svh */
// Assertion macros for the DNS name label encoder.
// Depends on signals named clock and reset in the including module.
`ifndef DNS_NAME_LABEL_ENCODER_TOP_ASSERT_SVH
`define DNS_NAME_LABEL_ENCODER_TOP_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define DNSL_ASSERT_NOW(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define DNSL_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

/* design/dnsl_pkg.sv */
// Shared types and constants for the DNS name label encoder.
// No dependencies.
`timescale 1ns / 1ps

package dnsl_pkg;

   localparam int MAX_LABEL_DEFAULT = 62;
   localparam int CHAR_W            = 8;
   localparam int LEN_W             = 6;

   localparam logic [CHAR_W-1:0] DOT_CHAR = 8'd46;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_END  = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LEN,
      S_DATA,
      S_TERM
   } state_type;

endpackage

/* design/dnsl_if.sv */
// Valid/ready channel interfaces for the request and response streams.
// Depends on dnsl_pkg for field widths.
`timescale 1ns / 1ps

interface dnsl_req_if;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [dnsl_pkg::CHAR_W-1:0] char_code;

   modport source (output valid, output op, output char_code, input ready);
   modport sink   (input valid, input op, input char_code, output ready);
endinterface

interface dnsl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dnsl_pkg::CHAR_W-1:0] out_byte;
   logic                        run_end;
   logic                        label_overflow;

   modport source (output valid, output out_byte, output run_end, output label_overflow,
                   input ready);
   modport sink   (input valid, input out_byte, input run_end, input label_overflow,
                   output ready);
endinterface

/* design/dns_name_label_encoder_top.sv */
// DNS name label encoder: character stream in, DNS wire-form bytes out.
// Depends on dnsl_pkg, dnsl_if and dns_name_label_encoder_top_assert.svh.
//
// A character that is not a dot is written to the label buffer and gives no
// output. A dot is accepted, then emits n+1 bytes (length, then the n buffered
// characters) at one byte per cycle while the response side is ready; an end
// item emits n+2 bytes, the last being the zero terminator. The single read
// port of the label buffer sets the one-byte-per-cycle output rate. New items
// are taken only while no label is being emitted, though the output register
// may still hold the last byte. Characters past MAX_LABEL are dropped and flag
// label_overflow on every byte until the name ends. No clearing pass is needed.
`timescale 1ns / 1ps
`include "dns_name_label_encoder_top_assert.svh"

module dns_name_label_encoder_top #(
   parameter int MAX_LABEL = dnsl_pkg::MAX_LABEL_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   dnsl_req_if.sink        req_ch,
   dnsl_rsp_if.source      rsp_ch
);

   localparam int CNT_W  = $clog2(MAX_LABEL + 1);
   localparam int ADDR_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
   localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_LABEL);

   logic [dnsl_pkg::CHAR_W-1:0] buf_mem [MAX_LABEL];

   dnsl_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                ovf_ff, ovf_in;
   logic                is_end_ff, is_end_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [dnsl_pkg::CHAR_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic                        rsp_end_ff, rsp_end_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;

   logic [dnsl_pkg::CHAR_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]           rd_addr;
   logic                        wr_en;

   logic req_xfer;
   logic out_free;
   logic is_dot;
   logic last_char;

   assign req_ch.ready = (state_ff == dnsl_pkg::S_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign is_dot       = (req_ch.char_code == dnsl_pkg::DOT_CHAR);
   assign last_char    = (idx_ff == count_ff - CNT_W'(1));

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.out_byte       = rsp_byte_ff;
   assign rsp_ch.run_end        = rsp_end_ff;
   assign rsp_ch.label_overflow = rsp_ovf_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dnsl_pkg::S_IDLE: begin
            if (req_xfer && (req_ch.op == dnsl_pkg::OP_END || is_dot)) begin
               state_in = dnsl_pkg::S_LEN;
            end
         end
         dnsl_pkg::S_LEN: begin
            if (out_free) begin
               if (count_ff != '0) begin
                  state_in = dnsl_pkg::S_DATA;
               end else if (is_end_ff) begin
                  state_in = dnsl_pkg::S_TERM;
               end else begin
                  state_in = dnsl_pkg::S_IDLE;
               end
            end
         end
         dnsl_pkg::S_DATA: begin
            if (out_free && last_char) begin
               state_in = is_end_ff ? dnsl_pkg::S_TERM : dnsl_pkg::S_IDLE;
            end
         end
         dnsl_pkg::S_TERM: begin
            if (out_free) begin
               state_in = dnsl_pkg::S_IDLE;
            end
         end
         default: state_in = dnsl_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      ovf_in       = ovf_ff;
      is_end_in    = is_end_ff;
      wr_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      case (state_ff)
         dnsl_pkg::S_IDLE: begin
            idx_in = '0;
            if (req_xfer) begin
               if (req_ch.op == dnsl_pkg::OP_END) begin
                  is_end_in = 1'b1;
               end else if (is_dot) begin
                  is_end_in = 1'b0;
               end else if (count_ff < LIMIT) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         dnsl_pkg::S_LEN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = dnsl_pkg::CHAR_W'(count_ff);
               rsp_end_in   = (count_ff == '0) && !is_end_ff;
               rsp_ovf_in   = ovf_ff;
            end
         end
         dnsl_pkg::S_DATA: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = rd_data_ff;
               rsp_end_in   = last_char && !is_end_ff;
               rsp_ovf_in   = ovf_ff;
               idx_in       = idx_ff + CNT_W'(1);
               if (last_char) begin
                  count_in = '0;
               end
            end
         end
         dnsl_pkg::S_TERM: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = '0;
               rsp_end_in   = 1'b1;
               rsp_ovf_in   = ovf_ff;
               ovf_in       = 1'b0;
            end
         end
         default: begin
            count_in = '0;
            ovf_in   = 1'b0;
         end
      endcase
      if (state_in == dnsl_pkg::S_IDLE && state_ff != dnsl_pkg::S_IDLE) begin
         count_in = '0;
      end
   end

   // read ahead at the next index so rd_data_ff always holds entry idx_ff
   assign rd_addr = (idx_in < LIMIT) ? idx_in[ADDR_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[count_ff[ADDR_W-1:0]] <= req_ch.char_code;
      end
      rd_data_ff <= buf_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dnsl_pkg::S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         ovf_ff       <= 1'b0;
         is_end_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         ovf_ff       <= ovf_in;
         is_end_ff    <= is_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   `DNSL_ASSERT_NOW(a_count_range, 1'b1, count_ff <= LIMIT,
      "label count above limit")
   `DNSL_ASSERT_NOW(a_idx_in_label, state_ff == dnsl_pkg::S_DATA, idx_ff < count_ff,
      "read index past label end")
   `DNSL_ASSERT_NEXT(a_name_end_clears, state_ff == dnsl_pkg::S_TERM && out_free,
      !ovf_ff && count_ff == '0 && state_ff == dnsl_pkg::S_IDLE,
      "state not cleared after name end")
   `DNSL_ASSERT_NEXT(a_len_loads_out, state_ff == dnsl_pkg::S_LEN && out_free,
      rsp_valid_ff && rsp_byte_ff == dnsl_pkg::CHAR_W'($past(count_ff)),
      "length byte not loaded")

endmodule

/* tb/sv/dnsl_wire_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the DNS name label encoder: watches both channels, predicts
// the wire-form bytes of every accepted item and compares them in order.
// Depends on dnsl_pkg and the channel interfaces in dnsl_if.

module dnsl_wire_checker (
   input  logic        clock,
   input  logic        reset,
   dnsl_req_if         req_ch,
   dnsl_rsp_if         rsp_ch,
   output int unsigned fail_count,
   output int unsigned bytes_pending
);

   localparam int LABEL_LIMIT = (dnsl_pkg::MAX_LABEL_DEFAULT > 62) ? 62
                                                                   : dnsl_pkg::MAX_LABEL_DEFAULT;
   localparam int PRINT_LIMIT = 50;

   typedef struct packed {
      logic [dnsl_pkg::CHAR_W-1:0] out_byte;
      logic                        run_end;
      logic                        label_overflow;
   } wire_byte_type;

   logic [dnsl_pkg::CHAR_W-1:0] label_chars [LABEL_LIMIT];
   logic [dnsl_pkg::LEN_W-1:0]  label_len = '0;
   logic                        name_overflow = 1'b0;
   wire_byte_type               wire_q [$];
   int unsigned                 mismatches = 0;
   int unsigned                 pending_cnt = 0;

   assign fail_count    = mismatches;
   assign bytes_pending = pending_cnt;

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT) begin
         $display("ERROR at %0t ns: %s", $time, msg);
      end
      mismatches++;
   endtask

   task automatic push_byte(input logic [dnsl_pkg::CHAR_W-1:0] b, input logic last);
      wire_byte_type e;
      e.out_byte       = b;
      e.run_end        = last;
      e.label_overflow = name_overflow;
      wire_q.push_back(e);
   endtask

   task automatic encode_item(input logic op, input logic [dnsl_pkg::CHAR_W-1:0] ch);
      if (op == dnsl_pkg::OP_CHAR && ch != dnsl_pkg::DOT_CHAR) begin
         if (label_len < LABEL_LIMIT) begin
            label_chars[label_len] = ch;
            label_len = label_len + 1'b1;
         end else begin
            name_overflow = 1'b1;
         end
      end else begin
         // length byte, then the held label; an end item adds the terminator
         push_byte(dnsl_pkg::CHAR_W'(label_len), op == dnsl_pkg::OP_CHAR && label_len == 0);
         for (int i = 0; i < label_len; i++) begin
            push_byte(label_chars[i], op == dnsl_pkg::OP_CHAR && i == label_len - 1);
         end
         label_len = '0;
         if (op == dnsl_pkg::OP_END) begin
            push_byte('0, 1'b1);
            name_overflow = 1'b0;
         end
      end
   endtask

   always @(posedge clock) begin
      wire_byte_type want;
      if (reset) begin
         label_len     = '0;
         name_overflow = 1'b0;
         wire_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (wire_q.size() == 0) begin
               report_mismatch($sformatf("byte 0x%02h with none expected", rsp_ch.out_byte));
            end else begin
               want = wire_q.pop_front();
               if (rsp_ch.out_byte !== want.out_byte) begin
                  report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                            rsp_ch.out_byte, want.out_byte));
               end
               if (rsp_ch.run_end !== want.run_end) begin
                  report_mismatch($sformatf("run_end %b, expected %b",
                                            rsp_ch.run_end, want.run_end));
               end
               if (rsp_ch.label_overflow !== want.label_overflow) begin
                  report_mismatch($sformatf("label_overflow %b, expected %b",
                                            rsp_ch.label_overflow, want.label_overflow));
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            encode_item(req_ch.op, req_ch.char_code);
         end
      end
      pending_cnt = wire_q.size();
   end

endmodule

/* tb/sv/tb_dns_name_label_encoder_top.sv */
`timescale 1ns / 1ps
// Testbench top for the DNS name label encoder: clock, reset, name stimulus,
// response-side stalls and the verdict. Depends on dnsl_pkg, dnsl_if,
// dns_name_label_encoder_top and dnsl_wire_checker.

module tb_dns_name_label_encoder_top;

   localparam int PHASE_ITEMS = 160;
   localparam int TOTAL_ITEMS = 440;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 3000;
   localparam int TAIL_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned fail_count;
   int unsigned bytes_pending;
   int unsigned tx_idle_pct = 29;
   int unsigned rx_idle_pct = 86;
   int unsigned items_sent = 0;
   int unsigned quiet_cycles = 0;
   logic        hold_request = 1'b0;
   logic        hold_off = 1'b0;

   dnsl_req_if req_ch ();
   dnsl_rsp_if rsp_ch ();

   dns_name_label_encoder_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   dnsl_wire_checker i_wire_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .fail_count    (fail_count),
      .bytes_pending (bytes_pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ch.ready <= !hold_off && ($urandom_range(99) >= rx_idle_pct);
   end

   // hold the response side off while names keep coming
   initial begin
      wait (hold_request);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic op, input logic [dnsl_pkg::CHAR_W-1:0] ch);
      logic taken;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.op        <= op;
      req_ch.char_code <= ch;
      do begin
         @(negedge clock);
         taken = req_ch.ready;
         @(posedge clock);
      end while (!taken);
      items_sent++;
      if (items_sent == PHASE_ITEMS) begin
         tx_idle_pct <= 86;
         rx_idle_pct <= 29;
      end else if (items_sent == 2 * PHASE_ITEMS) begin
         tx_idle_pct  <= 0;
         rx_idle_pct  <= 0;
         hold_request <= 1'b1;
      end
   endtask

   // well-formed names mostly, some noise and some names left unterminated
   task automatic send_random_name(input int forced_len);
      int                          kind;
      int                          labels;
      int                          len;
      logic [dnsl_pkg::CHAR_W-1:0] c;
      kind = $urandom_range(9);
      if (forced_len == 0 && kind == 0) begin
         repeat ($urandom_range(8, 1)) begin
            send_item(($urandom_range(3) == 0) ? dnsl_pkg::OP_END : dnsl_pkg::OP_CHAR,
                      $urandom_range(1) ? dnsl_pkg::DOT_CHAR
                                        : dnsl_pkg::CHAR_W'($urandom_range(255)));
         end
      end else if (forced_len == 0 && kind == 1) begin
         repeat ($urandom_range(12, 1)) begin
            send_item(dnsl_pkg::OP_CHAR,
                      ($urandom_range(2) == 0) ? dnsl_pkg::DOT_CHAR
                                               : dnsl_pkg::CHAR_W'($urandom_range(255)));
         end
      end else begin
         labels = $urandom_range(4, 1);
         for (int l = 0; l < labels; l++) begin
            if (l == 0 && forced_len > 0) begin
               len = forced_len;
            end else if ($urandom_range(11) == 0) begin
               len = $urandom_range(70, 55);
            end else begin
               len = $urandom_range(8);
            end
            repeat (len) begin
               do c = dnsl_pkg::CHAR_W'($urandom_range(255)); while (c == dnsl_pkg::DOT_CHAR);
               send_item(dnsl_pkg::OP_CHAR, c);
            end
            if (l < labels - 1 || $urandom_range(5) == 0) begin
               send_item(dnsl_pkg::OP_CHAR, dnsl_pkg::DOT_CHAR);
            end
         end
         send_item(dnsl_pkg::OP_END, dnsl_pkg::CHAR_W'($urandom_range(255)));
      end
   endtask

   initial begin
      req_ch.valid     <= 1'b0;
      req_ch.op        <= dnsl_pkg::OP_CHAR;
      req_ch.char_code <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty name, root dot, leading and doubled dots, extreme characters
      send_item(dnsl_pkg::OP_END, 8'h00);
      send_item(dnsl_pkg::OP_CHAR, dnsl_pkg::DOT_CHAR);
      send_item(dnsl_pkg::OP_END, 8'hFF);
      send_item(dnsl_pkg::OP_CHAR, dnsl_pkg::DOT_CHAR);
      send_item(dnsl_pkg::OP_CHAR, 8'h00);
      send_item(dnsl_pkg::OP_CHAR, 8'hFF);
      send_item(dnsl_pkg::OP_CHAR, dnsl_pkg::DOT_CHAR);
      send_item(dnsl_pkg::OP_CHAR, dnsl_pkg::DOT_CHAR);
      send_item(dnsl_pkg::OP_CHAR, 8'h55);
      send_item(dnsl_pkg::OP_CHAR, 8'hAA);
      send_item(dnsl_pkg::OP_CHAR, 8'h2D);
      send_item(dnsl_pkg::OP_CHAR, 8'h2F);
      send_item(dnsl_pkg::OP_CHAR, dnsl_pkg::DOT_CHAR);
      send_item(dnsl_pkg::OP_CHAR, 8'h61);
      send_item(dnsl_pkg::OP_END, dnsl_pkg::DOT_CHAR);
      send_item(dnsl_pkg::OP_CHAR, 8'h7A);
      send_item(dnsl_pkg::OP_CHAR, 8'h30);
      send_item(dnsl_pkg::OP_CHAR, dnsl_pkg::DOT_CHAR);
      send_item(dnsl_pkg::OP_END, 8'h00);

      while (items_sent < 2 * PHASE_ITEMS) send_random_name(0);
      // overflowing label and a label at the limit, sent into the hold-off
      send_random_name(66);
      send_random_name(62);
      while (items_sent < TOTAL_ITEMS) send_random_name(0);
      send_item(dnsl_pkg::OP_END, 8'h00);
      req_ch.valid <= 1'b0;

      do @(negedge clock); while (bytes_pending != 0);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/dnsl_pkg.sv
design/dnsl_if.sv
design/dns_name_label_encoder_top.sv
tb/sv/dnsl_wire_checker.sv
tb/sv/tb_dns_name_label_encoder_top.sv
